[rtl/audio_prebuffer_fifo_core_assert.svh]
// Assertion macros for the audio prebuffer FIFO.
// Used by the top level through a plain include; depends on nothing else.
`ifndef AUDIO_PREBUFFER_FIFO_CORE_ASSERT_SVH
`define AUDIO_PREBUFFER_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define APF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("audio prebuffer FIFO check failed");

// Next-cycle implication, disabled while reset is held.
`define APF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("audio prebuffer FIFO check failed");

`endif

[rtl/apf_pkg.sv]
// Shared types and constants of the audio prebuffer FIFO.
// Depends on nothing; used by the top level module.
package apf_pkg;

    // Storage sizes.
    localparam int RING_DEPTH = 16384;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int MAX_BLOCK  = 1024;

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int FILL_W     = 15;
    localparam int PREBUF_W   = 15;
    localparam int BLK_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register reset values.
    localparam int PREBUF_RESET = 8192;
    localparam int BLK_RESET    = 512;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_PULL    = 2'd1,
        OP_FINISH  = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_CLOSED  = 2'd2,
        ST_NO_DATA = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREBUFFER = 2'd0,
        CFG_BLOCK     = 2'd1
    } t_cfg_reg;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_op     op;
        t_sample sample_in;
    } t_in_item;

    typedef struct packed {
        t_sample             left_sample;
        t_sample             right_sample;
        logic                frame_valid;
        t_status             status;
        logic                drained;
        logic [FILL_W-1:0]   fill_level;
    } t_out_item;

endpackage

[rtl/audio_prebuffer_fifo_core.sv]
// Audio prebuffer FIFO: mono sample ring with prebuffer gate and block release.
// Items pass the input register, then the result register; throughput is one item per
// cycle without output stalls, set by the single-port-write, registered-read sample RAM.
// Reset (synchronous, active low) clears pointers, count, flags, block progress
// and loads the register defaults; the ring RAM is not cleared and needs no pass.
// Depends on apf_pkg and audio_prebuffer_fifo_core_assert.svh.
module audio_prebuffer_fifo_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  apf_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output apf_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [apf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [apf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import apf_pkg::*;

    `include "audio_prebuffer_fifo_core_assert.svh"

    // Sample ring.
    t_sample ring [RING_DEPTH];
    t_sample r_rd_data;

    // Configuration registers.
    logic [PREBUF_W-1:0] r_prebuf;
    logic [BLK_W-1:0]    r_blk_len;

    // Stream state.
    logic [PTR_W-1:0] r_wr_ptr,  n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr,  n_rd_ptr;
    logic [CNT_W-1:0] r_held,    n_held;
    logic             r_playing, n_playing;
    logic             r_closed,  n_closed;
    logic [BLK_W-1:0] r_blk_rem, n_blk_rem;

    // Input and result registers.
    logic       r_s1_valid;
    t_in_item   r_s1;
    logic       r_out_valid;
    t_out_item  r_res, n_res;

    logic             s1_adv;
    logic             push_wr;
    logic [BLK_W-1:0] eff_blk;

    // Handshakes: the result register frees when taken, the input stage when it moves on.
    assign s1_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    // Out-of-range block lengths fall back to the largest block.
    assign eff_blk = (r_blk_len == '0 || 32'(r_blk_len) > MAX_BLOCK) ?
                     BLK_W'(MAX_BLOCK) : r_blk_len;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prebuf  <= PREBUF_W'(PREBUF_RESET);
            r_blk_len <= BLK_W'(BLK_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PREBUFFER: r_prebuf  <= i_cfg_data[PREBUF_W-1:0];
                CFG_BLOCK:     r_blk_len <= i_cfg_data[BLK_W-1:0];
                default:       ;
            endcase
        end
    end

    // Operation decode and next stream state for the item in the input register.
    always_comb begin
        logic             v_play;
        logic [BLK_W-1:0] v_rem;
        v_play    = r_playing;
        v_rem     = r_blk_rem;
        n_wr_ptr  = r_wr_ptr;
        n_rd_ptr  = r_rd_ptr;
        n_held    = r_held;
        n_playing = r_playing;
        n_closed  = r_closed;
        n_blk_rem = r_blk_rem;
        push_wr   = 1'b0;
        n_res     = '0;
        n_res.status = ST_OK;
        case (r_s1.op)
            OP_PUSH: begin
                if (r_closed) begin
                    n_res.status = ST_CLOSED;
                end else if (32'(r_held) >= RING_DEPTH) begin
                    n_res.status = ST_FULL;
                end else begin
                    push_wr  = 1'b1;
                    n_wr_ptr = r_wr_ptr + 1'b1;
                    n_held   = r_held + 1'b1;
                end
            end
            OP_PULL: begin
                // Gate opens at the prebuffer level, or after finish with data held.
                if (!r_playing && (32'(r_held) >= 32'(r_prebuf) ||
                                   (r_closed && r_held != '0))) begin
                    v_play = 1'b1;
                end
                // Commit a new block: a whole one, or the remainder after finish.
                if (v_play && r_blk_rem == '0) begin
                    if (32'(r_held) >= 32'(eff_blk)) begin
                        v_rem = eff_blk;
                    end else if (r_closed) begin
                        v_rem = BLK_W'(r_held);
                    end
                end
                if (v_play && v_rem != '0 && r_held != '0) begin
                    n_res.frame_valid = 1'b1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                    n_held   = r_held - 1'b1;
                    v_rem    = v_rem - 1'b1;
                end else begin
                    n_res.status = ST_NO_DATA;
                end
                n_playing = v_play;
                n_blk_rem = v_rem;
            end
            OP_FINISH: begin
                n_closed = 1'b1;
            end
            OP_RESTART: begin
                n_wr_ptr  = '0;
                n_rd_ptr  = '0;
                n_held    = '0;
                n_playing = 1'b0;
                n_closed  = 1'b0;
                n_blk_rem = '0;
            end
            default: ;
        endcase
        n_res.drained    = n_closed && (n_held == '0);
        n_res.fill_level = FILL_W'(n_held);
    end

    // Control state, input register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_held      <= '0;
            r_playing   <= 1'b0;
            r_closed    <= 1'b0;
            r_blk_rem   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_wr_ptr  <= n_wr_ptr;
                r_rd_ptr  <= n_rd_ptr;
                r_held    <= n_held;
                r_playing <= n_playing;
                r_closed  <= n_closed;
                r_blk_rem <= n_blk_rem;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (s1_adv) begin
            r_res <= n_res;
        end
    end

    // Ring RAM: at most one write and one registered read per transfer.
    always_ff @(posedge i_clk) begin
        if (s1_adv && push_wr) begin
            ring[r_wr_ptr] <= r_s1.sample_in;
        end
        if (s1_adv) begin
            r_rd_data <= ring[r_rd_ptr];
        end
    end

    // Result assembly: the frame carries the read sample on both slots.
    always_comb begin
        o_out_data = r_res;
        if (r_res.frame_valid) begin
            o_out_data.left_sample  = r_rd_data;
            o_out_data.right_sample = r_rd_data;
        end
    end

    // The count always matches the pointer distance.
    `APF_ASSERT_IMPLY(a_count_matches_ptrs, i_clk, i_rst_n, 1'b1,
        r_held[PTR_W-1:0] == PTR_W'(r_wr_ptr - r_rd_ptr))
    // Block progress exists only once playback has started.
    `APF_ASSERT_IMPLY(a_block_needs_play, i_clk, i_rst_n, r_blk_rem != '0, r_playing)
    // A frame always comes with an ok status.
    `APF_ASSERT_IMPLY(a_frame_ok, i_clk, i_rst_n, o_out_valid && o_out_data.frame_valid,
        o_out_data.status == ST_OK)
    // A pending result reports the current stream state.
    `APF_ASSERT_IMPLY(a_drained_state, i_clk, i_rst_n, o_out_valid,
        o_out_data.drained == (r_closed && r_held == '0))
    // An emitted frame takes exactly one sample out of the ring.
    `APF_ASSERT_NEXT(a_frame_pops, i_clk, i_rst_n, s1_adv && n_res.frame_valid,
        r_held == $past(r_held) - 1'b1)

endmodule

[tb/tb_audio_prebuffer_fifo_core.sv]
// Self-checking testbench for the audio prebuffer FIFO core.
// Drives sample, pull, finish and restart transfers, predicts every output frame
// in place and compares it field by field. Depends on apf_pkg and the core RTL.
module tb_audio_prebuffer_fifo_core;
    timeunit 1ns;
    timeprecision 1ps;

    import apf_pkg::*;

    localparam int CLK_HIGH_NS     = 5;
    localparam int CLK_LOW_NS      = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 70;
    localparam int RANDOM_PHASES   = 6;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    // Index that maps to no register; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;

    // Block interface.
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted stream state and register copies.
    t_sample               ring_mem [RING_DEPTH];
    logic [PTR_W-1:0]      wr_ptr;
    logic [PTR_W-1:0]      rd_ptr;
    logic [CNT_W-1:0]      held;
    bit                    playing;
    bit                    closed;
    int unsigned           block_left;
    logic [PREBUF_W-1:0]   prebuf_level;
    logic [BLK_W-1:0]      block_len;

    // Frames predicted but not yet seen on the output.
    t_out_item             frames_due [$];
    int unsigned           error_count = 0;

    // Idle control shared between the sender and the receiver.
    bit                    src_steady  = 1'b0;
    bit                    sink_steady = 1'b0;
    bit                    sink_hold   = 1'b0;

    // Directed stimulus rows.
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        t_in_item              item;
        bit                    pinned;
        t_out_item             want;
    } t_script_row;

    t_script_row script [$];

    audio_prebuffer_fifo_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Free-running clock.
    always begin
        #(CLK_HIGH_NS) clk = 1'b1;
        #(CLK_LOW_NS)  clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("audio_prebuffer_fifo_core verification failed");
        $finish;
    end

    // Restart clears everything but the registers and the ring contents.
    function automatic void clear_stream();
        wr_ptr     = '0;
        rd_ptr     = '0;
        held       = '0;
        playing    = 1'b0;
        closed     = 1'b0;
        block_left = 0;
    endfunction

    // Advance the predicted stream by one accepted item and return its frame.
    function automatic t_out_item predict_frame(input t_in_item item);
        t_out_item   res;
        t_sample     emitted;
        int unsigned blk;
        res     = '0;
        emitted = '0;
        case (item.op)
            OP_PUSH: begin
                // A closed stream refuses before a full ring does.
                if (closed) begin
                    res.status = ST_CLOSED;
                end else if (held >= RING_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ring_mem[wr_ptr] = item.sample_in;
                    wr_ptr = wr_ptr + 1'b1;
                    held   = held + 1'b1;
                end
            end
            OP_PULL: begin
                if (!playing && (held >= prebuf_level || (closed && held != 0)))
                    playing = 1'b1;
                // Commit a whole block, or the remainder once the stream is closed.
                if (playing && block_left == 0) begin
                    blk = (block_len == 0 || block_len > MAX_BLOCK) ? MAX_BLOCK : block_len;
                    if (held >= blk)
                        block_left = blk;
                    else if (closed)
                        block_left = held;
                end
                if (playing && block_left != 0 && held != 0) begin
                    emitted    = ring_mem[rd_ptr];
                    rd_ptr     = rd_ptr + 1'b1;
                    held       = held - 1'b1;
                    block_left = block_left - 1;
                    res.frame_valid = 1'b1;
                end else begin
                    res.status = ST_NO_DATA;
                end
            end
            OP_FINISH: closed = 1'b1;
            default:   clear_stream();
        endcase
        res.left_sample  = emitted;
        res.right_sample = emitted;
        res.drained      = closed && held == 0;
        res.fill_level   = held[FILL_W-1:0];
        return res;
    endfunction

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int unsigned idle_gap(input bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Offer one item, hold it until the transfer, then record its expected frame.
    task automatic send_item(input t_in_item item, input bit pinned, input t_out_item fixed);
        int unsigned gap;
        t_out_item   pred;
        gap = idle_gap(src_steady);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        pred = predict_frame(item);
        frames_due.push_back(pinned ? fixed : pred);
    endtask

    // Wait until every predicted frame has come out and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PREBUFFER)
            prebuf_level = value[PREBUF_W-1:0];
        else if (idx == CFG_BLOCK)
            block_len = value[BLK_W-1:0];
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned push_pct;
        int unsigned r;
        t_in_item    item;
        push_pct = 50;
        for (int unsigned i = 0; i < count; i++) begin
            // Bias shifts every few items so the ring both fills and drains.
            if (i % 16 == 0)
                push_pct = $urandom_range(35, 70);
            r = $urandom_range(0, 99);
            if (r < push_pct)
                item.op = OP_PUSH;
            else if (r < 94)
                item.op = OP_PULL;
            else if (r < 97)
                item.op = OP_FINISH;
            else
                item.op = OP_RESTART;
            item.sample_in = t_sample'($urandom);
            send_item(item, 1'b0, '0);
        end
    endtask

    function automatic void add_op(input t_op op, input t_sample s);
        t_script_row row;
        row = '{default: '0};
        row.item.op        = op;
        row.item.sample_in = s;
        script.push_back(row);
    endfunction

    function automatic void add_pinned(input t_op op, input t_sample s, input t_sample out_s,
                                       input bit fv, input t_status st, input bit dr,
                                       input int unsigned fill);
        t_script_row row;
        row = '{default: '0};
        row.item.op          = op;
        row.item.sample_in   = s;
        row.pinned           = 1'b1;
        row.want.left_sample  = out_s;
        row.want.right_sample = out_s;
        row.want.frame_valid  = fv;
        row.want.status       = st;
        row.want.drained      = dr;
        row.want.fill_level   = fill[FILL_W-1:0];
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
        t_script_row row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = value;
        script.push_back(row);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    // Receiver: random stalls, quiet stretches, and one long hold on request.
    initial begin
        out_ready = 1'b1;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (sink_hold) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
                out_ready <= 1'b1;
            end else if (!sink_steady && $urandom_range(0, 99) < 20) begin
                out_ready <= 1'b0;
                repeat (idle_gap(1'b0) + 1) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Each output transfer must match the oldest predicted frame.
    always @(posedge clk) begin : frame_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t ns: frame with nothing expected, actual %h", $time, out_data);
                error_count++;
            end else begin
                want = frames_due.pop_front();
                check_field("left_sample", want.left_sample, out_data.left_sample);
                check_field("right_sample", want.right_sample, out_data.right_sample);
                check_field("frame_valid", want.frame_valid, out_data.frame_valid);
                check_field("status", want.status, out_data.status);
                check_field("drained", want.drained, out_data.drained);
                check_field("fill_level", want.fill_level, out_data.fill_level);
            end
        end
    end

    // Main sequence.
    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        clear_stream();
        prebuf_level = PREBUF_W'(PREBUF_RESET);
        block_len    = BLK_W'(BLK_RESET);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, finish on an empty ring, a push after finish.
        add_pinned(OP_PULL, 16'sh0000, 16'sh0000, 1'b0, ST_NO_DATA, 1'b0, 0);
        add_pinned(OP_FINISH, 16'sh0000, 16'sh0000, 1'b0, ST_OK, 1'b1, 0);
        add_pinned(OP_PUSH, 16'sh7FFF, 16'sh0000, 1'b0, ST_CLOSED, 1'b1, 0);
        add_pinned(OP_RESTART, 16'sh0000, 16'sh0000, 1'b0, ST_OK, 1'b0, 0);
        // Gate at three samples, blocks of two, extreme sample values.
        add_cfg(CFG_PREBUFFER, 15'd3);
        add_cfg(CFG_BLOCK, 15'd2);
        add_pinned(OP_PUSH, 16'sh8000, 16'sh0000, 1'b0, ST_OK, 1'b0, 1);
        add_pinned(OP_PULL, 16'sh0000, 16'sh0000, 1'b0, ST_NO_DATA, 1'b0, 1);
        add_pinned(OP_PUSH, 16'sh7FFF, 16'sh0000, 1'b0, ST_OK, 1'b0, 2);
        add_pinned(OP_PUSH, 16'sh0000, 16'sh0000, 1'b0, ST_OK, 1'b0, 3);
        add_pinned(OP_PULL, 16'sh0000, 16'sh8000, 1'b1, ST_OK, 1'b0, 2);
        add_pinned(OP_PULL, 16'sh0000, 16'sh7FFF, 1'b1, ST_OK, 1'b0, 1);
        // Less than a block held before finish: no data.
        add_pinned(OP_PULL, 16'sh0000, 16'sh0000, 1'b0, ST_NO_DATA, 1'b0, 1);
        // Still playing after running dry, so the next full block goes out.
        add_op(OP_PUSH, 16'sh5A5A);
        add_op(OP_PULL, 16'sh0000);
        add_op(OP_FINISH, 16'sh0000);
        add_op(OP_FINISH, 16'shFFFF);
        add_pinned(OP_PUSH, 16'shFFFF, 16'sh0000, 1'b0, ST_CLOSED, 1'b0, 1);
        add_op(OP_PULL, 16'sh0000);
        add_op(OP_RESTART, 16'sh0000);
        // Zero gate opens at the first pull; zero block length means the largest block.
        add_cfg(CFG_PREBUFFER, 15'd0);
        add_cfg(CFG_BLOCK, 15'd0);
        add_pinned(OP_PULL, 16'sh0000, 16'sh0000, 1'b0, ST_NO_DATA, 1'b0, 0);
        add_op(OP_PUSH, 16'sh1234);
        add_op(OP_PULL, 16'sh0000);
        add_op(OP_FINISH, 16'sh0000);
        add_op(OP_PULL, 16'sh0000);
        // Gate above the ring depth opens only on finish; oversized block is clamped.
        add_cfg(CFG_PREBUFFER, 15'h7FFF);
        add_cfg(CFG_BLOCK, 15'h07FF);
        add_op(OP_RESTART, 16'sh0000);
        add_op(OP_PUSH, 16'sh0001);
        add_op(OP_PULL, 16'sh0000);
        add_op(OP_FINISH, 16'sh0000);
        add_op(OP_PULL, 16'sh0000);

        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_reg(script[i].cfg_idx, script[i].cfg_val);
            else
                send_item(script[i].item, script[i].pinned, script[i].want);
        end

        // Random phases over a range of register settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_PREBUFFER, 15'($urandom_range(1, 24)));
                    write_reg(CFG_BLOCK, 15'($urandom_range(1, 6)));
                end
                1: begin
                    // Upper data bits fall outside the block register.
                    write_reg(CFG_PREBUFFER, 15'($urandom_range(2, 40)));
                    write_reg(CFG_BLOCK,
                              15'(($urandom_range(1, 15) << BLK_W) | $urandom_range(1, 8)));
                end
                2: begin
                    write_reg(CFG_PREBUFFER, 15'd0);
                    write_reg(CFG_BLOCK, 15'd0);
                end
                3: begin
                    write_reg(CFG_IDX_UNMAPPED, 15'h7FFF);
                    write_reg(CFG_PREBUFFER, 15'd1);
                    write_reg(CFG_BLOCK, 15'd1);
                end
                4: begin
                    write_reg(CFG_PREBUFFER, 15'h7FFF);
                    write_reg(CFG_BLOCK, 15'h7FFF);
                end
                default: begin
                    write_reg(CFG_PREBUFFER, 15'($urandom_range(1, 16)));
                    write_reg(CFG_BLOCK, 15'($urandom_range(1, 4)));
                end
            endcase
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            // Last phase: receiver holds off while the sender keeps offering.
            if (phase == RANDOM_PHASES - 1) begin
                src_steady = 1'b1;
                sink_hold  = 1'b1;
            end
            run_random(PHASE_ITEMS);
        end

        // Wind down and report.
        in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && frames_due.size() == 0)
            $display("audio_prebuffer_fifo_core verification clean");
        else
            $display("audio_prebuffer_fifo_core verification failed");
        $finish;
    end

endmodule
